FILE: sv/gdc_pkg.sv
package gdc_pkg;

  typedef logic [21:0] serial_t;
  typedef logic [13:0] year_t;

  // Request codes
  localparam logic FN_LOAD = 1'b0;
  localparam logic FN_ADD  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DATE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam year_t      BASE_YEAR  = 14'd1601;
  localparam logic [3:0] LAST_STEP  = 4'd13;
  localparam logic [3:0] LAST_MONTH = 4'd12;

  // Year weight of each restoring step: 400-year groups (5 bits),
  // centuries (2 bits), 4-year groups (5 bits), single years (2 bits).
  function automatic logic [12:0] step_years(input logic [3:0] idx);
    logic [12:0] v;
    unique case (idx)
      4'd0:    v = 13'd6400;
      4'd1:    v = 13'd3200;
      4'd2:    v = 13'd1600;
      4'd3:    v = 13'd800;
      4'd4:    v = 13'd400;
      4'd5:    v = 13'd200;
      4'd6:    v = 13'd100;
      4'd7:    v = 13'd64;
      4'd8:    v = 13'd32;
      4'd9:    v = 13'd16;
      4'd10:   v = 13'd8;
      4'd11:   v = 13'd4;
      4'd12:   v = 13'd2;
      4'd13:   v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

  // Day weight of the same steps.
  function automatic serial_t step_days(input logic [3:0] idx);
    serial_t v;
    unique case (idx)
      4'd0:    v = 22'd2337552;
      4'd1:    v = 22'd1168776;
      4'd2:    v = 22'd584388;
      4'd3:    v = 22'd292194;
      4'd4:    v = 22'd146097;
      4'd5:    v = 22'd73048;
      4'd6:    v = 22'd36524;
      4'd7:    v = 22'd23376;
      4'd8:    v = 22'd11688;
      4'd9:    v = 22'd5844;
      4'd10:   v = 22'd2922;
      4'd11:   v = 22'd1461;
      4'd12:   v = 22'd730;
      4'd13:   v = 22'd365;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // Days of the year before the first of a month.
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] mon);
    logic [8:0] v;
    unique case (mon)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = leap ? 9'd60  : 9'd59;
      4'd4:    v = leap ? 9'd91  : 9'd90;
      4'd5:    v = leap ? 9'd121 : 9'd120;
      4'd6:    v = leap ? 9'd152 : 9'd151;
      4'd7:    v = leap ? 9'd182 : 9'd181;
      4'd8:    v = leap ? 9'd213 : 9'd212;
      4'd9:    v = leap ? 9'd244 : 9'd243;
      4'd10:   v = leap ? 9'd274 : 9'd273;
      4'd11:   v = leap ? 9'd305 : 9'd304;
      4'd12:   v = leap ? 9'd335 : 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] mon);
    logic [4:0] v;
    unique case (mon)
      4'd2:                     v = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  v = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:       v = 5'd31;
      default:                  v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/gregorian_day_counter.sv
// Gregorian day counter: holds one day number, day 1 being 1 January 1601.
//
// Input channel (in_valid / in_stall): one request per item. in_func selects
// a load of in_day_in / in_month_in / in_year_in, or an add of the signed
// in_delta_days. A load with a bad date leaves the count as it was and
// reports status 1; an add that would leave 1 .. 31 December MAX_YEAR is
// refused with status 2.
// Result channel (out_valid / out_stall): exactly one result per request,
// the stored date as day, month, year and day number, plus the status.
//
// Timing: one request at a time; in_stall stays high until the result sits
// in the output register. A load with its year out of range and an add
// leaving the span go straight to the result; all other requests run the
// 14 restoring steps of the shared subtractor that split years into 400-,
// 100-, 4- and 1-year groups, plus 4 month-search steps and one day step
// on the same subtractor for an add.
// A held result (out_stall high) blocks only the final write-back; the
// next request is taken as soon as the result enters the output register.
// Reset: synchronous, active low; the count returns to 1 January 1601.
module gregorian_day_counter #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [4:0]            in_day_in,
  input  logic [3:0]            in_month_in,
  input  logic [13:0]           in_year_in,
  input  logic signed [21:0]    in_delta_days,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [4:0]            out_day_out,
  output logic [3:0]            out_month_out,
  output logic [13:0]           out_year_out,
  output gdc_pkg::serial_t      out_serial_out,
  output logic [1:0]            out_status
);
  import gdc_pkg::*;

  // Last valid day number: days in all years 1601 .. MAX_YEAR.
  localparam int SpanYears = MAX_YEAR - 1600;
  localparam int MaxSerial = SpanYears * 365 + SpanYears / 4 - SpanYears / 100
                             + SpanYears / 400;
  localparam year_t        MaxYearW   = 14'(MAX_YEAR);
  localparam logic [23:0]  MaxSerialW = 24'(MaxSerial);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_LCHK  = 3'd3;
  localparam logic [2:0] S_MSRCH = 3'd4;
  localparam logic [2:0] S_MDAY  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic               func_r, func_nxt;
  logic [4:0]         day_in_r, day_in_nxt;
  logic [3:0]         month_in_r, month_in_nxt;
  year_t              year_in_r, year_in_nxt;
  logic signed [21:0] delta_r, delta_nxt;
  serial_t            rem_r, rem_nxt;     // years left (load) or days left (add)
  serial_t            acc_r, acc_nxt;     // days gathered (load) or years gathered (add)
  logic [3:0]         idx_r, idx_nxt;
  logic [13:0]        taken_r, taken_nxt; // one bit per restoring step
  logic [3:0]         mon_r, mon_nxt;
  logic [1:0]         bcnt_r, bcnt_nxt;
  serial_t            serial_r, serial_nxt;
  logic [4:0]         st_day_r, st_day_nxt;
  logic [3:0]         st_mon_r, st_mon_nxt;
  year_t              st_year_r, st_year_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [4:0]         out_day_r, out_day_nxt;
  logic [3:0]         out_mon_r, out_mon_nxt;
  year_t              out_year_r, out_year_nxt;
  serial_t            out_serial_r, out_serial_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  serial_t            opb;
  logic [22:0]        diff;
  logic               borrow;
  logic               leap;
  logic [3:0]         try_mon;
  logic [23:0]        sum_w;
  logic               date_ok;

  assign in_stall = ~rst_n | (state_r != S_IDLE);

  // Leap year from the quotient bits: last year of a 4-year group, and not
  // the last year of a century unless it closes a 400-year group.
  assign leap = (taken_r[1:0] == 2'b11) &&
                ((taken_r[6:2] != 5'd24) || (taken_r[8:7] == 2'b11));

  assign try_mon = mon_r | (4'b1000 >> bcnt_r);

  // Shared subtractor: remainder minus a step weight or a month offset
  always_comb begin
    unique case (state_r)
      S_STEP:  opb = (func_r == FN_ADD) ? step_days(idx_r)
                                        : {9'd0, step_years(idx_r)};
      S_MSRCH: opb = {13'd0, cum_days(leap, try_mon)};
      S_MDAY:  opb = {13'd0, cum_days(leap, mon_r)};
      default: opb = '0;
    endcase
  end

  assign diff   = {1'b0, rem_r} - {1'b0, opb};
  assign borrow = diff[22];

  assign sum_w = {2'b00, serial_r} + {{2{delta_r[21]}}, delta_r};

  assign date_ok = (month_in_r >= 4'd1) && (month_in_r <= LAST_MONTH) &&
                   (day_in_r != 5'd0) && (day_in_r <= month_days(leap, month_in_r));

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    day_in_nxt     = day_in_r;
    month_in_nxt   = month_in_r;
    year_in_nxt    = year_in_r;
    delta_nxt      = delta_r;
    rem_nxt        = rem_r;
    acc_nxt        = acc_r;
    idx_nxt        = idx_r;
    taken_nxt      = taken_r;
    mon_nxt        = mon_r;
    bcnt_nxt       = bcnt_r;
    serial_nxt     = serial_r;
    st_day_nxt     = st_day_r;
    st_mon_nxt     = st_mon_r;
    st_year_nxt    = st_year_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_day_nxt    = out_day_r;
    out_mon_nxt    = out_mon_r;
    out_year_nxt   = out_year_r;
    out_serial_nxt = out_serial_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          func_nxt     = in_func;
          day_in_nxt   = in_day_in;
          month_in_nxt = in_month_in;
          year_in_nxt  = in_year_in;
          delta_nxt    = in_delta_days;
          state_nxt    = S_PREP;
        end
      end
      S_PREP: begin
        acc_nxt = '0;
        idx_nxt = '0;
        if (func_r == FN_LOAD) begin
          if ((year_in_r >= BASE_YEAR) && (year_in_r <= MaxYearW)) begin
            rem_nxt   = {8'd0, year_in_r - BASE_YEAR};
            state_nxt = S_STEP;
          end else begin
            status_nxt = ST_BAD_DATE;
            state_nxt  = S_OUT;
          end
        end else begin
          // Refuse sums below day 1 or past the last day of MAX_YEAR
          if (sum_w[23] || (sum_w == 24'd0) || (sum_w > MaxSerialW)) begin
            status_nxt = ST_RANGE;
            state_nxt  = S_OUT;
          end else begin
            serial_nxt = sum_w[21:0];
            rem_nxt    = sum_w[21:0] - 22'd1;
            state_nxt  = S_STEP;
          end
        end
      end
      S_STEP: begin
        taken_nxt = {taken_r[12:0], ~borrow};
        if (!borrow) begin
          rem_nxt = diff[21:0];
          acc_nxt = acc_r + ((func_r == FN_ADD) ? {9'd0, step_years(idx_r)}
                                                : step_days(idx_r));
        end
        idx_nxt = idx_r + 4'd1;
        if (idx_r == LAST_STEP) begin
          mon_nxt   = '0;
          bcnt_nxt  = '0;
          state_nxt = (func_r == FN_ADD) ? S_MSRCH : S_LCHK;
        end
      end
      S_LCHK: begin
        if (date_ok) begin
          serial_nxt  = acc_r + {13'd0, cum_days(leap, month_in_r)} + {17'd0, day_in_r};
          st_day_nxt  = day_in_r;
          st_mon_nxt  = month_in_r;
          st_year_nxt = year_in_r;
          status_nxt  = ST_OK;
        end else begin
          status_nxt  = ST_BAD_DATE;
        end
        state_nxt = S_OUT;
      end
      S_MSRCH: begin
        // Keep the largest month whose start lies at or before the day
        if (!borrow && (try_mon <= LAST_MONTH)) begin
          mon_nxt = try_mon;
        end
        bcnt_nxt = bcnt_r + 2'd1;
        if (bcnt_r == 2'd3) begin
          state_nxt = S_MDAY;
        end
      end
      S_MDAY: begin
        st_day_nxt  = diff[4:0] + 5'd1;
        st_mon_nxt  = mon_r;
        st_year_nxt = BASE_YEAR + acc_r[13:0];
        status_nxt  = ST_OK;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_day_nxt    = st_day_r;
          out_mon_nxt    = st_mon_r;
          out_year_nxt   = st_year_r;
          out_serial_nxt = serial_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      serial_r    <= 22'd1;
      st_day_r    <= 5'd1;
      st_mon_r    <= 4'd1;
      st_year_r   <= BASE_YEAR;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      serial_r    <= serial_nxt;
      st_day_r    <= st_day_nxt;
      st_mon_r    <= st_mon_nxt;
      st_year_r   <= st_year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    day_in_r     <= day_in_nxt;
    month_in_r   <= month_in_nxt;
    year_in_r    <= year_in_nxt;
    delta_r      <= delta_nxt;
    rem_r        <= rem_nxt;
    acc_r        <= acc_nxt;
    idx_r        <= idx_nxt;
    taken_r      <= taken_nxt;
    mon_r        <= mon_nxt;
    bcnt_r       <= bcnt_nxt;
    status_r     <= status_nxt;
    out_day_r    <= out_day_nxt;
    out_mon_r    <= out_mon_nxt;
    out_year_r   <= out_year_nxt;
    out_serial_r <= out_serial_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_day_out    = out_day_r;
  assign out_month_out  = out_mon_r;
  assign out_year_out   = out_year_r;
  assign out_serial_out = out_serial_r;
  assign out_status     = out_status_r;

endmodule

FILE: sv/gdc_checker.sv
module gdc_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [4:0]       out_day_out,
  input logic [3:0]       out_month_out,
  input logic [13:0]      out_year_out,
  input gdc_pkg::serial_t out_serial_out,
  input logic [1:0]       out_status
);
  import gdc_pkg::*;

  // Busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still in work");

  // A held result stays valid and keeps its day number
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_serial_out))
    else $error("held result dropped or changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_BAD_DATE) ||
                  (out_status == ST_RANGE))
    else $error("undefined status code");

  a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_out >= 4'd1) && (out_month_out <= LAST_MONTH) &&
                  (out_day_out != 5'd0) && (out_year_out >= BASE_YEAR) &&
                  (out_serial_out != 22'd0))
    else $error("stored date out of its span");

endmodule

bind gregorian_day_counter gdc_checker u_gdc_checker (.*);

FILE: verif/gregorian_day_counter_tb.sv
module gregorian_day_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gdc_pkg::*;

  localparam int MAX_YEAR = 9999;
  localparam int YEAR_SPAN = MAX_YEAR - 1600;
  // Day number of 31 December MAX_YEAR, the top of the supported span.
  localparam int LAST_DAY_NUM =
    YEAR_SPAN * 365 + YEAR_SPAN / 4 - YEAR_SPAN / 100 + YEAR_SPAN / 400;
  localparam int RANDOM_COUNT = 1225;
  // Requests at the tail of the run go back to back on both sides.
  localparam int QUIET_TAIL = 150;

  typedef struct packed {
    logic       func;
    logic [4:0] day;
    logic [3:0] month;
    year_t      year;
    logic [21:0] delta;
  } date_request_t;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    year_t      year;
    serial_t    serial;
    logic [1:0] status;
  } date_result_t;

  typedef struct packed {
    date_request_t req;
    logic          typed;
    date_result_t  want;
  } stim_row_t;

  localparam date_result_t PREDICTED = '0;
  localparam int DIRECTED_COUNT = 25;

  // Directed requests. Rows with typed set carry an expected result that is
  // plain from the request alone; the rest go through the date predictor.
  localparam stim_row_t DIRECTED [DIRECTED_COUNT] = '{
    // after reset: 1 January 1601, then refuse steps below day 1
    '{'{FN_ADD, 5'd0, 4'd0, 14'd0, 22'd0}, 1'b1, '{5'd1, 4'd1, 14'd1601, 22'd1, ST_OK}},
    '{'{FN_ADD, 5'd0, 4'd0, 14'd0, 22'h200000}, 1'b1,
      '{5'd1, 4'd1, 14'd1601, 22'd1, ST_RANGE}},
    '{'{FN_ADD, 5'd0, 4'd0, 14'd0, 22'h3FFFFF}, 1'b1,
      '{5'd1, 4'd1, 14'd1601, 22'd1, ST_RANGE}},
    // malformed dates: day 0, month 0, month 13, all fields at maximum,
    // year one below the base, year one past the top
    '{'{FN_LOAD, 5'd0, 4'd1, 14'd1601, 22'd0}, 1'b1,
      '{5'd1, 4'd1, 14'd1601, 22'd1, ST_BAD_DATE}},
    '{'{FN_LOAD, 5'd1, 4'd0, 14'd1601, 22'd0}, 1'b1,
      '{5'd1, 4'd1, 14'd1601, 22'd1, ST_BAD_DATE}},
    '{'{FN_LOAD, 5'd1, 4'd13, 14'd1601, 22'd0}, 1'b1,
      '{5'd1, 4'd1, 14'd1601, 22'd1, ST_BAD_DATE}},
    '{'{FN_LOAD, 5'd31, 4'd15, 14'd16383, 22'd0}, 1'b1,
      '{5'd1, 4'd1, 14'd1601, 22'd1, ST_BAD_DATE}},
    '{'{FN_LOAD, 5'd31, 4'd1, 14'd1600, 22'd0}, 1'b1,
      '{5'd1, 4'd1, 14'd1601, 22'd1, ST_BAD_DATE}},
    '{'{FN_LOAD, 5'd1, 4'd1, 14'd10000, 22'd0}, 1'b1,
      '{5'd1, 4'd1, 14'd1601, 22'd1, ST_BAD_DATE}},
    // last supported day, then refuse steps past it
    '{'{FN_LOAD, 5'd31, 4'd12, 14'd9999, 22'd0}, 1'b1,
      '{5'd31, 4'd12, 14'd9999, 22'd3067671, ST_OK}},
    '{'{FN_ADD, 5'd0, 4'd0, 14'd0, 22'd1}, 1'b1,
      '{5'd31, 4'd12, 14'd9999, 22'd3067671, ST_RANGE}},
    '{'{FN_ADD, 5'd0, 4'd0, 14'd0, 22'h1FFFFF}, 1'b1,
      '{5'd31, 4'd12, 14'd9999, 22'd3067671, ST_RANGE}},
    '{'{FN_ADD, 5'd0, 4'd0, 14'd0, 22'h200000}, 1'b0, PREDICTED},
    // leap-day rules: 400-year leap, century non-leap, plain leap
    '{'{FN_LOAD, 5'd29, 4'd2, 14'd2000, 22'd0}, 1'b0, PREDICTED},
    '{'{FN_LOAD, 5'd29, 4'd2, 14'd1900, 22'd0}, 1'b0, PREDICTED},
    '{'{FN_LOAD, 5'd29, 4'd2, 14'd1604, 22'd0}, 1'b0, PREDICTED},
    '{'{FN_LOAD, 5'd30, 4'd2, 14'd2000, 22'd0}, 1'b0, PREDICTED},
    '{'{FN_LOAD, 5'd31, 4'd4, 14'd2023, 22'd0}, 1'b0, PREDICTED},
    '{'{FN_LOAD, 5'd30, 4'd4, 14'd2023, 22'd0}, 1'b0, PREDICTED},
    '{'{FN_LOAD, 5'd1, 4'd1, 14'd1601, 22'd0}, 1'b1, '{5'd1, 4'd1, 14'd1601, 22'd1, ST_OK}},
    '{'{FN_ADD, 5'd0, 4'd0, 14'd0, 22'h1FFFFF}, 1'b0, PREDICTED},
    // month and year rollover in both directions
    '{'{FN_LOAD, 5'd1, 4'd3, 14'd2100, 22'd0}, 1'b0, PREDICTED},
    '{'{FN_ADD, 5'd0, 4'd0, 14'd0, 22'h3FFFFF}, 1'b0, PREDICTED},
    '{'{FN_LOAD, 5'd31, 4'd12, 14'd2400, 22'd0}, 1'b0, PREDICTED},
    '{'{FN_ADD, 5'd0, 4'd0, 14'd0, 22'd1}, 1'b0, PREDICTED}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = FN_LOAD;
  logic [4:0]  in_day_in = '0;
  logic [3:0]  in_month_in = '0;
  logic [13:0] in_year_in = '0;
  logic signed [21:0] in_delta_days = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_day_out;
  logic [3:0]  out_month_out;
  logic [13:0] out_year_out;
  serial_t     out_serial_out;
  logic [1:0]  out_status;

  // Day number held by the predictor, updated as each request is accepted.
  int           stored_day_num;
  date_result_t expected_dates[$];
  int           mismatches = 0;
  // Random idling on both sides is allowed only while this is set.
  bit           idling_on = 1'b0;

  gregorian_day_counter #(
    .MAX_YEAR(MAX_YEAR)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_day_in(in_day_in),
    .in_month_in(in_month_in),
    .in_year_in(in_year_in),
    .in_delta_days(in_delta_days),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_day_out(out_day_out),
    .out_month_out(out_month_out),
    .out_year_out(out_year_out),
    .out_serial_out(out_serial_out),
    .out_status(out_status)
  );

  // Days in the first n years counted from 1601.
  function automatic int days_before_year(int n);
    return n * 365 + n / 4 - n / 100 + n / 400;
  endfunction

  function automatic bit is_leap_year(int y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic int days_in_month(int y, int m);
    case (m)
      2:              return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  // Apply one request to the stored day number and return the date it
  // leaves behind, with its status.
  function automatic date_result_t predict_date(date_request_t r);
    date_result_t res;
    int d, m, y, sum, n, doy;
    res.status = ST_OK;
    if (r.func == FN_LOAD) begin
      d = r.day;
      m = r.month;
      y = r.year;
      if (y < 1601 || y > MAX_YEAR || m < 1 || m > 12 || d < 1 || d > days_in_month(y, m)) begin
        res.status = ST_BAD_DATE;
      end else begin
        sum = days_before_year(y - 1601) + d;
        for (int k = 1; k < m; k++) sum += days_in_month(y, k);
        stored_day_num = sum;
      end
    end else begin
      sum = stored_day_num + int'($signed(r.delta));
      if (sum < 1 || sum > LAST_DAY_NUM) res.status = ST_RANGE;
      else stored_day_num = sum;
    end
    // Walk up to the year holding the day, then peel off whole months.
    n = (stored_day_num - 1) / 366;
    while (days_before_year(n + 1) < stored_day_num) n++;
    y = 1601 + n;
    doy = stored_day_num - days_before_year(n);
    m = 1;
    while (doy > days_in_month(y, m)) begin
      doy -= days_in_month(y, m);
      m++;
    end
    res.day = 5'(doy);
    res.month = 4'(m);
    res.year = 14'(y);
    res.serial = 22'(stored_day_num);
    return res;
  endfunction

  // Mostly well-formed loads and adds that stay in the span, plus malformed
  // dates, wild deltas and adds aimed at both ends of the span.
  function automatic date_request_t random_request();
    date_request_t r;
    int pick, y, m, target, delta;
    r.func = FN_LOAD;
    r.day = 5'($urandom);
    r.month = 4'($urandom);
    r.year = 14'($urandom);
    r.delta = 22'($urandom);
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 4))
      0:       y = 1601;
      1:       y = MAX_YEAR;
      2:       y = 100 * $urandom_range(17, 99);
      default: y = $urandom_range(1601, MAX_YEAR);
    endcase
    m = $urandom_range(1, 12);
    if (pick < 35) begin
      r.year = 14'(y);
      r.month = 4'(m);
      if ($urandom_range(0, 2) == 0) r.day = 5'(days_in_month(y, m));
      else r.day = 5'($urandom_range(1, days_in_month(y, m)));
    end else if (pick < 47) begin
      // Keep the raw fields half the time; else step one day past month end.
      if ($urandom_range(0, 1) == 1) begin
        r.year = 14'(y);
        r.month = 4'(m);
        r.day = 5'(days_in_month(y, m) + 1);
      end
    end else begin
      r.func = FN_ADD;
      if (pick < 80) begin
        r.delta = 22'(int'($urandom_range(0, 1600)) - 800);
      end else if (pick >= 90) begin
        case ($urandom_range(0, 5))
          0:       target = 0;
          1:       target = 1;
          2:       target = 2;
          3:       target = LAST_DAY_NUM - 1;
          4:       target = LAST_DAY_NUM;
          default: target = LAST_DAY_NUM + 1;
        endcase
        delta = target - stored_day_num;
        if (delta >= -2097152 && delta <= 2097151) r.delta = 22'(delta);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("gregorian_day_counter verification failed");
    $finish;
  end

  // Request side: hold reset, then send the directed rows
  // followed by the random requests. Each request is held until accepted,
  // and its expected result is queued at the edge where it goes in.
  initial begin
    date_request_t req;
    date_result_t  want;
    int            total;
    total = DIRECTED_COUNT + RANDOM_COUNT;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    stored_day_num = 1;
    for (int i = 0; i < total; i++) begin
      // Idle in three stretches of 120 requests out of every 480, and never at the tail.
      idling_on = (i < total - QUIET_TAIL) && ((i / 120) % 4 != 3);
      if (i < DIRECTED_COUNT) req = DIRECTED[i].req;
      else req = random_request();
      if (idling_on && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      in_func <= req.func;
      in_day_in <= req.day;
      in_month_in <= req.month;
      in_year_in <= req.year;
      in_delta_days <= req.delta;
      in_valid <= 1'b1;
      do @(posedge clk); while (in_stall);
      want = predict_date(req);
      if (i < DIRECTED_COUNT && DIRECTED[i].typed) want = DIRECTED[i].want;
      expected_dates.push_back(want);
    end
    in_valid <= 1'b0;
    idling_on = 1'b0;
    // Drain, then give the block time to show any stray result.
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("gregorian_day_counter verification clean");
    end else begin
      $display("gregorian_day_counter verification failed");
    end
    $finish;
  end

  // Result side: stall in random bursts while idling is allowed.
  initial begin
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted result with the oldest expected date.
  always @(posedge clk) begin
    date_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("result with no request pending", out_serial_out, 0);
      end else begin
        want = expected_dates.pop_front();
        if (out_day_out !== want.day) report_mismatch("day", out_day_out, want.day);
        if (out_month_out !== want.month) report_mismatch("month", out_month_out, want.month);
        if (out_year_out !== want.year) report_mismatch("year", out_year_out, want.year);
        if (out_serial_out !== want.serial)
          report_mismatch("day number", out_serial_out, want.serial);
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
      end
    end
  end

endmodule
